// ===== rtl/b64enc_pkg.sv =====
// package: constants, types and the sextet mapping of the base64 stream encoder
`default_nettype none
package b64enc_pkg;

	localparam int DATA_W = 8;
	localparam int CHAR_W = 8;
	localparam int APB_DW = 32;
	localparam int APB_AW = 4;
	localparam int MAX_CHARS = 4;
	localparam int IDX_W = $clog2(MAX_CHARS);

	localparam logic [CHAR_W-1:0] CHAR_PAD = 8'h3D;
	localparam logic [CHAR_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_LF = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;

	localparam logic [CHAR_W-1:0] RST_CHAR62 = 8'd43;
	localparam logic [CHAR_W-1:0] RST_CHAR63 = 8'd47;
	localparam logic RST_PAD_EN = 1'b1;
	localparam logic [CHAR_W-1:0] RST_LINE_LEN = 8'd0;

	typedef enum logic [1:0] {
		REG_CHAR62 = 2'd0,
		REG_CHAR63 = 2'd1,
		REG_PAD_EN = 2'd2,
		REG_LINE_LEN = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		EMIT_CHAR,
		EMIT_CR,
		EMIT_LF
	} emit_state_t;

	typedef logic [CHAR_W-1:0] char_t;

	function automatic char_t map_sextet(input logic [5:0] v, input char_t c62,
			input char_t c63);
		char_t r;
		if (v < 6'd26) begin
			r = CHAR_UPPER_A + {2'b00, v};
		end else if (v < 6'd52) begin
			r = CHAR_LOWER_A + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = CHAR_DIGIT_0 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = c62;
		end else begin
			r = c63;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/b64enc_if.sv =====
// stream interfaces: raw byte requests in, encoded character requests out
`default_nettype none
interface b64enc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64enc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/base64_stream_encoder.sv =====
// top level: streaming base64 encoder with configurable 62/63 characters and line wrap
//
//   channel    dir   handshake      payload
//   byte_in    in    valid/ready    data_byte[7:0], last_byte
//   char_out   out   valid/ready    out_char[7:0], out_last
//   apb        in    psel/penable   paddr[3:0], pwdata[31:0] -> prdata[31:0], pready
//
// an accepted byte is mapped to its 1 to 4 characters (data, flush, '=') and written
// into the s1 register; the emitter then sends one character per cycle, while the
// output register is free or being taken, inserting cr lf after each full line
// the next byte is taken in the cycle its predecessor's final character leaves s1
// arst_n clears the group phase, line count and all valid flags; registers go
// to their documented reset values
`default_nettype none
module base64_stream_encoder (
	input  wire                            clk,
	input  wire                            arst_n,
	b64enc_in_if.sink                      byte_in,
	b64enc_out_if.source                   char_out,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [b64enc_pkg::APB_AW-1:0]  paddr,
	input  wire  [b64enc_pkg::APB_DW-1:0]  pwdata,
	output logic [b64enc_pkg::APB_DW-1:0]  prdata,
	output logic                           pready
);
	import b64enc_pkg::*;

	// configuration registers
	char_t             char62_q, char63_q, line_len_q;
	logic              pad_en_q;
	reg_idx_t          reg_sel;
	logic              cfg_wr;

	// encoder group state, updated when a byte is taken
	logic [1:0]        phase_q;
	logic [3:0]        leftover_q;

	// s1: characters of one item waiting to be sent
	logic              valid_s1;
	char_t             chars_s1 [MAX_CHARS];
	logic [IDX_W-1:0]  last_idx_s1;
	logic              last_s1;

	// emitter
	emit_state_t       emit_q;
	logic [IDX_W-1:0]  idx_q;
	char_t             line_count_q;

	// output register
	logic              ov_q;
	char_t             ochar_q;
	logic              olast_q;

	// combinational
	char_t             enc_chars [MAX_CHARS];
	logic [IDX_W-1:0]  enc_last_idx;
	logic [1:0]        next_phase;
	logic [3:0]        next_leftover;
	logic              accept;
	logic              advance;
	logic              finish;
	char_t             emit_char;
	logic              emit_last;
	emit_state_t       emit_next;
	logic [IDX_W-1:0]  idx_next;
	char_t             line_count_next;
	char_t             lc_inc;
	logic              wrap;
	logic              final_char;

	// apb register file
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char62_q   <= RST_CHAR62;
			char63_q   <= RST_CHAR63;
			pad_en_q   <= RST_PAD_EN;
			line_len_q <= RST_LINE_LEN;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_CHAR62:   char62_q   <= pwdata[CHAR_W-1:0];
				REG_CHAR63:   char63_q   <= pwdata[CHAR_W-1:0];
				REG_PAD_EN:   pad_en_q   <= pwdata[0];
				REG_LINE_LEN: line_len_q <= pwdata[CHAR_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_CHAR62:   prdata[CHAR_W-1:0] = char62_q;
			REG_CHAR63:   prdata[CHAR_W-1:0] = char63_q;
			REG_PAD_EN:   prdata[0]          = pad_en_q;
			REG_LINE_LEN: prdata[CHAR_W-1:0] = line_len_q;
			default:      prdata             = '0;
		endcase
	end

	// byte to characters, including flush and padding on the final byte
	always_comb begin
		for (int i = 0; i < MAX_CHARS; i++) begin
			enc_chars[i] = CHAR_PAD;
		end
		enc_last_idx  = '0;
		next_phase    = 2'd0;
		next_leftover = 4'd0;
		case (phase_q)
			2'd1: begin
				enc_chars[0]  = map_sextet({leftover_q[1:0], byte_in.data_byte[7:4]},
					char62_q, char63_q);
				next_phase    = 2'd2;
				next_leftover = byte_in.data_byte[3:0];
				if (byte_in.last_byte) begin
					enc_chars[1] = map_sextet({byte_in.data_byte[3:0], 2'b00},
						char62_q, char63_q);
					enc_last_idx = pad_en_q ? IDX_W'(2) : IDX_W'(1);
				end
			end
			2'd2: begin
				enc_chars[0]  = map_sextet({leftover_q, byte_in.data_byte[7:6]},
					char62_q, char63_q);
				enc_chars[1]  = map_sextet(byte_in.data_byte[5:0], char62_q, char63_q);
				enc_last_idx  = IDX_W'(1);
			end
			default: begin
				// phase three never arises and is handled as phase zero
				enc_chars[0]  = map_sextet(byte_in.data_byte[7:2], char62_q, char63_q);
				next_phase    = 2'd1;
				next_leftover = {2'b00, byte_in.data_byte[1:0]};
				if (byte_in.last_byte) begin
					enc_chars[1] = map_sextet({byte_in.data_byte[1:0], 4'b0000},
						char62_q, char63_q);
					enc_last_idx = pad_en_q ? IDX_W'(3) : IDX_W'(1);
				end
			end
		endcase
		if (byte_in.last_byte) begin
			next_phase    = 2'd0;
			next_leftover = 4'd0;
		end
	end

	// emitter: one character, cr or lf per cycle into the output register, while it is free or being taken
	assign advance    = valid_s1 && (!ov_q || char_out.ready);
	assign final_char = (idx_q == last_idx_s1);
	assign lc_inc     = line_count_q + 8'd1;
	assign wrap       = (line_len_q != '0) && (lc_inc >= line_len_q);

	always_comb begin
		emit_char       = chars_s1[idx_q];
		emit_last       = 1'b0;
		emit_next       = emit_q;
		idx_next        = idx_q;
		line_count_next = line_count_q;
		finish          = 1'b0;
		case (emit_q)
			EMIT_CHAR: begin
				if (line_len_q != '0) begin
					line_count_next = lc_inc;
				end
				if (wrap) begin
					line_count_next = '0;
					emit_next       = EMIT_CR;
				end else if (final_char) begin
					emit_last = 1'b1;
					finish    = 1'b1;
					idx_next  = '0;
				end else begin
					idx_next = idx_q + IDX_W'(1);
				end
			end
			EMIT_CR: begin
				emit_char = CHAR_CR;
				emit_next = EMIT_LF;
			end
			EMIT_LF: begin
				emit_char = CHAR_LF;
				emit_next = EMIT_CHAR;
				if (final_char) begin
					emit_last = 1'b1;
					finish    = 1'b1;
					idx_next  = '0;
				end else begin
					idx_next = idx_q + IDX_W'(1);
				end
			end
			default: begin
				emit_next = EMIT_CHAR;
			end
		endcase
		// the message end starts the next line afresh
		if (finish && last_s1) begin
			line_count_next = '0;
		end
	end

	// a new byte enters when s1 is empty or releases its final character now
	assign byte_in.ready = !valid_s1 || (advance && finish);
	assign accept        = byte_in.valid && byte_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= 2'd0;
			leftover_q   <= 4'd0;
			valid_s1     <= 1'b0;
			emit_q       <= EMIT_CHAR;
			idx_q        <= '0;
			line_count_q <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= next_phase;
				leftover_q <= next_leftover;
				valid_s1   <= 1'b1;
			end else if (advance && finish) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				emit_q       <= emit_next;
				idx_q        <= idx_next;
				line_count_q <= line_count_next;
				ov_q         <= 1'b1;
			end else if (char_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			chars_s1    <= enc_chars;
			last_idx_s1 <= enc_last_idx;
			last_s1     <= byte_in.last_byte;
		end
		if (advance) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign char_out.valid    = ov_q;
	assign char_out.out_char = ochar_q;
	assign char_out.out_last = olast_q;

endmodule
`default_nettype wire

// ===== bench/base64_stream_encoder_tb.sv =====
// testbench: random and directed byte streams checked against a cycle-free base64 encoder model
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
	import b64enc_pkg::*;

	// one raw byte request and one encoded character as the bench tracks them
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} byte_item_t;

	typedef struct packed {
		char_t ch;
		logic  fin;
	} char_rec_t;

	// clock, reset and every block input start at known values
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic       in_valid = 1'b0;
	logic [7:0] in_data = 8'h00;
	logic       in_last = 1'b0;
	logic       out_ready = 1'b0;

	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [APB_AW-1:0]   paddr = '0;
	logic [APB_DW-1:0]   pwdata = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	b64enc_in_if  byte_in ();
	b64enc_out_if char_out ();

	assign byte_in.valid = in_valid;
	assign byte_in.data_byte = in_data;
	assign byte_in.last_byte = in_last;
	assign char_out.ready = out_ready;

	base64_stream_encoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.char_out(char_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #10 clk = ~clk;

	// bytes waiting to be offered, characters still owed by the block
	byte_item_t byte_queue[$];
	char_rec_t  awaited_chars[$];
	char_t      step_chars[$];
	int         mismatches = 0;

	// idle chance per cycle, in percent, for each side
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;

	// shadow copy of the configuration registers
	char_t      cfg_c62 = RST_CHAR62;
	char_t      cfg_c63 = RST_CHAR63;
	logic       cfg_pad = RST_PAD_EN;
	logic [7:0] cfg_line_len = RST_LINE_LEN;

	// encoder state as the block should hold it
	logic [1:0] grp_phase = 2'd0;
	logic [3:0] carry_bits = 4'd0;
	logic [7:0] line_cnt = 8'd0;

	// first 62 symbols are fixed, the last two come from the registers
	string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

	function automatic char_t sextet_to_char(input logic [5:0] v);
		char_t c;
		if (v == 6'd62) begin
			c = cfg_c62;
		end else if (v == 6'd63) begin
			c = cfg_c63;
		end else begin
			c = b64_digits[v];
		end
		return c;
	endfunction

	// one encoded or pad character, followed by cr lf when it fills the line
	task automatic put_encoded(input char_t c);
		step_chars.push_back(c);
		if (cfg_line_len != 8'd0) begin
			line_cnt = line_cnt + 8'd1;
			if (line_cnt >= cfg_line_len) begin
				step_chars.push_back(CHAR_CR);
				step_chars.push_back(CHAR_LF);
				line_cnt = 8'd0;
			end
		end
	endtask

	// works out every character one accepted byte request causes
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		int pads;
		char_rec_t rec;
		pads = 0;
		step_chars.delete();
		case (grp_phase)
			2'd1: begin
				put_encoded(sextet_to_char({carry_bits[1:0], b[7:4]}));
				carry_bits = b[3:0];
				grp_phase = 2'd2;
			end
			2'd2: begin
				put_encoded(sextet_to_char({carry_bits, b[7:6]}));
				put_encoded(sextet_to_char(b[5:0]));
				carry_bits = 4'd0;
				grp_phase = 2'd0;
			end
			default: begin
				put_encoded(sextet_to_char(b[7:2]));
				carry_bits = {2'b00, b[1:0]};
				grp_phase = 2'd1;
			end
		endcase
		if (fin) begin
			// flush the partial sextet, then pad to a four-character group when padding is on
			if (grp_phase == 2'd1) begin
				put_encoded(sextet_to_char({carry_bits[1:0], 4'b0000}));
				pads = 2;
			end else if (grp_phase == 2'd2) begin
				put_encoded(sextet_to_char({carry_bits, 2'b00}));
				pads = 1;
			end
			if (cfg_pad) begin
				for (int k = 0; k < pads; k++) begin
					put_encoded(CHAR_PAD);
				end
			end
			grp_phase = 2'd0;
			carry_bits = 4'd0;
			line_cnt = 8'd0;
		end
		for (int k = 0; k < step_chars.size(); k++) begin
			rec.ch = step_chars[k];
			rec.fin = (k == step_chars.size() - 1);
			awaited_chars.push_back(rec);
		end
	endtask

	// byte request driver: holds a request until taken, idles at random between requests
	always @(posedge clk) begin
		byte_item_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || byte_in.ready) begin
			if (in_valid) begin
				encode_byte(in_data, in_last);
			end
			if (byte_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				next_item = byte_queue.pop_front();
				in_valid <= 1'b1;
				in_data <= next_item.data;
				in_last <= next_item.fin;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// character monitor: checks each taken character against the oldest one owed
	always @(posedge clk) begin
		char_rec_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (char_out.valid && out_ready) begin
				if (awaited_chars.size() == 0) begin
					$display("%0t: unexpected character: expected none, got %h last %b",
						$time, char_out.out_char, char_out.out_last);
					mismatches++;
				end else begin
					want = awaited_chars.pop_front();
					if (char_out.out_char !== want.ch) begin
						$display("%0t: out_char mismatch: expected %h, got %h",
							$time, want.ch, char_out.out_char);
						mismatches++;
					end
					if (char_out.out_last !== want.fin) begin
						$display("%0t: out_last mismatch: expected %b, got %b",
							$time, want.fin, char_out.out_last);
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		byte_item_t it;
		it.data = b;
		it.fin = fin;
		byte_queue.push_back(it);
	endtask

	// a whole message of random bytes, extremes mixed in now and then
	task automatic queue_message(input int len);
		logic [7:0] b;
		for (int k = 0; k < len; k++) begin
			case ($urandom_range(7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom_range(255));
			endcase
			queue_byte(b, k == len - 1);
		end
	endtask

	// sender holds off until the block has sent everything it owes
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (byte_queue.size() != 0 || in_valid || awaited_chars.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// apb write: setup then access, junk above the register width
	task automatic apb_write(input reg_idx_t idx, input logic [7:0] val);
		logic [APB_DW-1:0] word;
		word = $urandom();
		if (idx == REG_PAD_EN) begin
			word[0] = val[0];
		end else begin
			word[7:0] = val;
		end
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_CHAR62: cfg_c62 = val;
			REG_CHAR63: cfg_c63 = val;
			REG_PAD_EN: cfg_pad = val[0];
			default: cfg_line_len = val;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] c62, input logic [7:0] c63,
			input logic pad, input logic [7:0] len);
		apb_write(REG_CHAR62, c62);
		apb_write(REG_CHAR63, c63);
		apb_write(REG_PAD_EN, {7'd0, pad});
		apb_write(REG_LINE_LEN, len);
	endtask

	// random messages, mostly short, some long; occasional full drain
	task automatic run_phase(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
			queue_message(len);
			sent += len;
			if ($urandom_range(15) == 0) begin
				wait_idle();
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles a quarter of the time, receiver most of it
		tx_idle_pct = 25;
		rx_idle_pct = 87;

		// directed: reset config, one-byte flush with two pads
		queue_byte(8'h00, 1'b1);
		// two bytes, one pad
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// sextets 62 and 63 twice, full group with no flush
		queue_byte(8'hFB, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hBF, 1'b1);
		// four bytes, crosses a group boundary
		queue_byte(8'h4D, 1'b0);
		queue_byte(8'h61, 1'b0);
		queue_byte(8'h6E, 1'b0);
		queue_byte(8'h80, 1'b1);
		wait_idle();

		// padding off: flush only
		apb_write(REG_PAD_EN, 8'd0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hAA, 1'b1);
		wait_idle();

		// line break right after the final pad
		apb_write(REG_PAD_EN, 8'd1);
		apb_write(REG_LINE_LEN, 8'd4);
		queue_byte(8'h00, 1'b1);
		// two characters on the line, then the limit drops to that count
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h02, 1'b0);
		wait_idle();
		apb_write(REG_LINE_LEN, 8'd2);
		queue_byte(8'h03, 1'b0);
		queue_byte(8'h04, 1'b1);
		wait_idle();

		// wrapping switched off mid-line keeps the count frozen
		apb_write(REG_LINE_LEN, 8'd3);
		queue_byte(8'h10, 1'b0);
		wait_idle();
		apb_write(REG_LINE_LEN, 8'd0);
		queue_byte(8'h20, 1'b0);
		wait_idle();
		apb_write(REG_LINE_LEN, 8'd3);
		queue_byte(8'h30, 1'b1);
		wait_idle();

		// random phases, reset-like config then the extremes
		set_config(8'd43, 8'd47, 1'b1, 8'd0);
		run_phase(30);
		set_config(8'd0, 8'd255, 1'b0, 8'd1);
		run_phase(30);

		// receiver now mostly ready, sender mostly idle
		tx_idle_pct = 87;
		rx_idle_pct = 25;
		set_config(8'd255, 8'd0, 1'b1, 8'd255);
		// long enough to fill a 255-character line
		queue_message(191);
		run_phase(30);
		set_config(8'd45, 8'd95, 1'b0, 8'd76);
		run_phase(30);

		// no idling on either side
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
			1'($urandom_range(1)), 8'($urandom_range(1, 10)));
		run_phase(30);
		set_config(8'd43, 8'd47, 1'b1, 8'd4);
		run_phase(30);

		// drain, then watch for stray characters
		wait_idle();
		repeat (16) @(negedge clk);
		if (mismatches == 0 && awaited_chars.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
